[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the RTL. They compile to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[design/ftcc_pkg.sv]
// ----------------------------------------------------------------------------
// ftcc_pkg
// Constants and register codes of the feed-through crosstalk correction.
// ----------------------------------------------------------------------------
`default_nettype none

package ftcc_pkg;

    localparam int DEFAULT_SAMPLE_BITS = 12;

    // Fixed-point formats: alpha is Q0.16, gain is Q8.16.
    localparam int FRAC_BITS  = 16;
    localparam int ALPHA_BITS = 16;
    localparam int GAIN_BITS  = 24;

    localparam logic [GAIN_BITS-1:0] GAIN_ONE = GAIN_BITS'(1) << FRAC_BITS;

    // Configuration port.
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 24;

    localparam logic [CFG_INDEX_BITS-1:0] REG_ALPHA_FRACTION   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RECIP_GAIN       = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SATURATION_LIMIT = 2'd2;

endpackage

`default_nettype wire

[design/ftcc_in_if.sv]
// ----------------------------------------------------------------------------
// ftcc_in_if
// Input channel: one detector sample word with its plane-start mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface ftcc_in_if
    import ftcc_pkg::*;
#(
    parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS
) ();

    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   first_channel;

    modport source (output valid, output sample, output first_channel, input ready);
    modport sink   (input valid, input sample, input first_channel, output ready);

endinterface

`default_nettype wire

[design/ftcc_out_if.sv]
// ----------------------------------------------------------------------------
// ftcc_out_if
// Output channel: one corrected sample word.
// ----------------------------------------------------------------------------
`default_nettype none

interface ftcc_out_if
    import ftcc_pkg::*;
#(
    parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS
) ();

    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] corrected;

    modport source (output valid, output corrected, input ready);
    modport sink   (input valid, input corrected, output ready);

endinterface

`default_nettype wire

[design/ftcc_mul.sv]
// ----------------------------------------------------------------------------
// ftcc_mul
// Shared unsigned multiplier with a registered product, used for both the
// crosstalk term and the gain scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module ftcc_mul #(
    parameter int A_BITS = 28,
    parameter int B_BITS = 24
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic [A_BITS-1:0]        a,
    input  wire logic [B_BITS-1:0]        b,
    output logic      [A_BITS+B_BITS-1:0] product
);

    logic [A_BITS+B_BITS-1:0] product_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            product_reg <= (A_BITS+B_BITS)'(a) * (A_BITS+B_BITS)'(b);
        end
    end

    assign product = product_reg;

endmodule

`default_nettype wire

[design/feedthrough_crosstalk_correction.sv]
// ----------------------------------------------------------------------------
// feedthrough_crosstalk_correction
// Removes the feed-through share of the previous channel from each sample.
// ----------------------------------------------------------------------------
// Usage:
// Samples of one plane enter on the samples channel in scan order, one word
// per channel; first_channel marks the first channel of a plane scan, for
// which the previous corrected value is taken as zero. Each sample yields
// exactly one corrected word on the results channel:
//   corrected = clamp(round((sample - prev * alpha) * gain), 0, limit)
// Coefficients are written on the cfg port while the block is idle.
// Timing: a word is accepted in the idle state, then one shared multiplier
// computes prev * alpha, a subtract stage forms the difference, the same
// multiplier scales it by the gain, and a final stage clamps and rounds.
// The result is registered in the final stage, and the block returns to
// idle and takes the next sample only then: the recursion through two
// products on the single multiplier bars a new sample before the last is through.
// A stalled receiver holds the result in the output register; the block then
// accepts and processes one more sample and waits in its final stage until
// the output register is free. Reset clears the previous value to zero and
// loads alpha 0, gain 1.0 and the largest saturation limit.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module feedthrough_crosstalk_correction
    import ftcc_pkg::*;
#(
    parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
    ftcc_in_if.sink                        samples,
    ftcc_out_if.source                     results
);

    localparam int DIFF_BITS  = SAMPLE_BITS + FRAC_BITS;
    localparam int PROD_BITS  = DIFF_BITS + GAIN_BITS;
    localparam int SHIFT      = 2 * FRAC_BITS;
    localparam int HIGH_BITS  = PROD_BITS - SHIFT;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL1 = 3'd1;
    localparam logic [2:0] S_SUB  = 3'd2;
    localparam logic [2:0] S_MUL2 = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]             state_reg, state_next;

    logic [ALPHA_BITS-1:0]  alpha_reg;
    logic [GAIN_BITS-1:0]   gain_reg;
    logic [SAMPLE_BITS-1:0] limit_reg;
    logic [SAMPLE_BITS-1:0] prev_reg;

    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [SAMPLE_BITS-1:0] op_prev_reg;
    logic [DIFF_BITS-1:0]   diff_reg;
    logic                   neg_reg;

    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] out_data_reg;

    logic                   mul_en;
    logic [DIFF_BITS-1:0]   mul_a;
    logic [GAIN_BITS-1:0]   mul_b;
    logic [PROD_BITS-1:0]   mul_p;

    logic                   accept;
    logic                   out_free;
    logic                   fin_go;
    logic [DIFF_BITS-1:0]   pos;
    logic [DIFF_BITS-1:0]   neg;
    logic [HIGH_BITS-1:0]   high;
    logic [HIGH_BITS-1:0]   rounded;
    logic                   sat_hit;
    logic [SAMPLE_BITS-1:0] result;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= '0;
            gain_reg  <= GAIN_ONE;
            limit_reg <= '1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ALPHA_FRACTION:   alpha_reg <= cfg_data[ALPHA_BITS-1:0];
                REG_RECIP_GAIN:       gain_reg  <= cfg_data[GAIN_BITS-1:0];
                REG_SATURATION_LIMIT: limit_reg <= cfg_data[SAMPLE_BITS-1:0];
                default:              ;
            endcase
        end
    end

    assign accept   = samples.valid && samples.ready;
    assign out_free = !out_valid_reg || results.ready;
    assign fin_go   = (state_reg == S_FIN) && out_free;

    assign samples.ready     = (state_reg == S_IDLE);
    assign results.valid     = out_valid_reg;
    assign results.corrected = out_data_reg;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_en = 1'b0;
        mul_a  = DIFF_BITS'(op_prev_reg);
        mul_b  = GAIN_BITS'(alpha_reg);
        if (state_reg == S_MUL1)
        begin
            mul_en = 1'b1;
        end
        else if (state_reg == S_MUL2)
        begin
            mul_en = 1'b1;
            mul_a  = diff_reg;
            mul_b  = gain_reg;
        end
    end

    ftcc_mul #(
        .A_BITS (DIFF_BITS),
        .B_BITS (GAIN_BITS)
    ) u_mul (
        .clk     (clk),
        .en      (mul_en),
        .a       (mul_a),
        .b       (mul_b),
        .product (mul_p)
    );

    // Difference stage: the crosstalk term fits in DIFF_BITS by construction.
    assign pos = {sample_reg, {FRAC_BITS{1'b0}}};
    assign neg = mul_p[DIFF_BITS-1:0];

    // Clamp and round half up. When the high part is below the limit the
    // rounding carry cannot leave the sample range.
    assign high    = mul_p[PROD_BITS-1:SHIFT];
    assign sat_hit = (high >= HIGH_BITS'(limit_reg));
    assign rounded = high + HIGH_BITS'(mul_p[SHIFT-1]);

    always_comb
    begin
        if (neg_reg)
        begin
            result = '0;
        end
        else if (sat_hit)
        begin
            result = limit_reg;
        end
        else
        begin
            result = rounded[SAMPLE_BITS-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (accept) state_next = S_MUL1;
            S_MUL1:  state_next = S_SUB;
            S_SUB:   state_next = S_MUL2;
            S_MUL2:  state_next = S_FIN;
            S_FIN:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (fin_go)
            begin
                prev_reg      <= result;
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg  <= samples.sample;
            op_prev_reg <= samples.first_channel ? '0 : prev_reg;
        end
        if (state_reg == S_SUB)
        begin
            neg_reg  <= (neg > pos);
            diff_reg <= pos - neg;
        end
        if (fin_go)
        begin
            out_data_reg <= result;
        end
    end

    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, accept, !samples.ready)
    `ASSERT_NEXT(a_neg_gives_zero, clk, rst_n, fin_go && neg_reg, results.valid && results.corrected == '0)
    `ASSERT_NEXT(a_prev_tracks_out, clk, rst_n, fin_go, prev_reg == out_data_reg)
    `ASSERT_IMPLIES(a_mul_only_in_mul_states, clk, rst_n, mul_en, state_reg == S_MUL1 || state_reg == S_MUL2)

endmodule

`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Feed-through crosstalk correction testbench
// Drives detector samples in plane scans through the correction block and
// compares every corrected word against a bit-exact predictor of the
// fixed-point recursion. Coefficients are changed between phases while the
// block is idle. Sender gaps and receiver stalls vary from phase to phase,
// and one long receiver hold-off fills the block.
// ----------------------------------------------------------------------------

module testbench;
    import ftcc_pkg::*;

    localparam int SB          = DEFAULT_SAMPLE_BITS;
    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int ITEMS_PER_PHASE = 450;

    // The block has no register at this index; writes to it must be ignored.
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = 2'd3;

    typedef struct {
        logic [SB-1:0] corrected;
        logic [SB-1:0] sample;
        logic          first;
    } corr_word_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    ftcc_in_if  #(.SAMPLE_BITS(SB)) samples_ch ();
    ftcc_out_if #(.SAMPLE_BITS(SB)) results_ch ();

    feedthrough_crosstalk_correction #(.SAMPLE_BITS(SB)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samples   (samples_ch),
        .results   (results_ch)
    );

    // Shadow copy of the coefficients and of the recursion state.
    logic [ALPHA_BITS-1:0] alpha_q16  = '0;
    logic [GAIN_BITS-1:0]  gain_q16   = GAIN_ONE;
    logic [SB-1:0]         limit_lvl  = '1;
    logic [SB-1:0]         prev_level = '0;

    corr_word_t pending_corrected[$];
    corr_word_t seen_word;
    int         bad_words    = 0;
    int         quiet_cycles = 0;
    int         send_idle_pct = 0;
    int         stall_pct     = 0;
    int         hold_left     = 0;
    bit         moved;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        samples_ch.valid = 1'b0;
        samples_ch.sample = '0;
        samples_ch.first_channel = 1'b0;
    end

    // Receiver: random stalls, plus a long hold-off counted down here.
    initial
    begin
        results_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                results_ch.ready <= 1'b0;
                hold_left = hold_left - 1;
            end
            else
            begin
                results_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    function automatic logic [SB-1:0] predict_corrected(input logic [SB-1:0] smp,
                                                        input logic first);
        logic [63:0]   base;
        logic [63:0]   pos;
        logic [63:0]   neg;
        logic [63:0]   diff;
        logic [63:0]   prod;
        logic [SB-1:0] res;
        base = first ? 64'd0 : 64'(prev_level);
        pos  = 64'(smp) << FRAC_BITS;
        neg  = base * 64'(alpha_q16);
        if (neg > pos)
        begin
            res = '0;
        end
        else
        begin
            diff = pos - neg;
            prod = diff * 64'(gain_q16);
            if (prod >= (64'(limit_lvl) << 32))
                res = limit_lvl;
            else
                res = SB'((prod + (64'd1 << 31)) >> 32);
        end
        prev_level = res;
        return res;
    endfunction

    // Monitor: tracks register writes, predicts each accepted sample word and
    // checks each accepted corrected word against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ALPHA_FRACTION:   alpha_q16 = cfg_data[ALPHA_BITS-1:0];
                    REG_RECIP_GAIN:       gain_q16  = cfg_data[GAIN_BITS-1:0];
                    REG_SATURATION_LIMIT: limit_lvl = cfg_data[SB-1:0];
                    default: ;
                endcase
            end
            moved = 1'b0;
            if (samples_ch.valid && samples_ch.ready)
            begin
                seen_word.sample    = samples_ch.sample;
                seen_word.first     = samples_ch.first_channel;
                seen_word.corrected = predict_corrected(samples_ch.sample,
                                                        samples_ch.first_channel);
                pending_corrected.push_back(seen_word);
                moved = 1'b1;
            end
            if (results_ch.valid && results_ch.ready)
            begin
                moved = 1'b1;
                if (pending_corrected.size() == 0)
                begin
                    bad_words++;
                    if (bad_words <= 10)
                        $display("unexpected corrected word %0d at %0t",
                                 results_ch.corrected, $realtime);
                end
                else
                begin
                    seen_word = pending_corrected.pop_front();
                    if (seen_word.corrected !== results_ch.corrected)
                    begin
                        bad_words++;
                        if (bad_words <= 10)
                            $display("corrected: expected %0d got %0d (sample %0d first %0b)",
                                     seen_word.corrected, results_ch.corrected,
                                     seen_word.sample, seen_word.first);
                    end
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
        end
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("feedthrough_crosstalk_correction: mismatch");
        $finish;
    end

    task automatic send_channel(input logic [SB-1:0] smp, input logic first);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            samples_ch.valid <= 1'b0;
            @(posedge clk);
        end
        samples_ch.valid <= 1'b1;
        samples_ch.sample <= smp;
        samples_ch.first_channel <= first;
        @(posedge clk);
        while (!samples_ch.ready)
            @(posedge clk);
    endtask

    // Stop sending and wait until every predicted word has come out. The
    // first edge lets the monitor record the word accepted at the last one.
    task automatic drain;
        samples_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_corrected.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_coeffs(input logic [CFG_DATA_BITS-1:0] alpha_word,
                              input logic [CFG_DATA_BITS-1:0] gain_word,
                              input logic [CFG_DATA_BITS-1:0] limit_word);
        cfg_we <= 1'b1;
        cfg_index <= REG_ALPHA_FRACTION;
        cfg_data <= alpha_word;
        @(posedge clk);
        cfg_index <= REG_RECIP_GAIN;
        cfg_data <= gain_word;
        @(posedge clk);
        cfg_index <= REG_SATURATION_LIMIT;
        cfg_data <= limit_word;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Random coefficients, extremes included; unused high bits are filled.
    task automatic pick_coeffs;
        logic [ALPHA_BITS-1:0] a;
        logic [63:0]           g;
        logic [SB-1:0]         lim;
        case ($urandom_range(5))
            0:       a = '0;
            1:       a = '1;
            2:       a = ALPHA_BITS'($urandom_range(1, 6554));
            default: a = ALPHA_BITS'($urandom);
        endcase
        case ($urandom_range(7))
            0:       g = 64'(GAIN_ONE);
            1:       g = 64'hFF_FFFF;
            2:       g = 64'($urandom_range(0, 65535));
            3:       g = 64'($urandom) & 64'hFF_FFFF;
            default: g = (64'd1 << 32) / (64'd65536 - 64'(a));
        endcase
        if (g > 64'hFF_FFFF)
            g = 64'hFF_FFFF;
        case ($urandom_range(9))
            0:       lim = '0;
            1:       lim = SB'($urandom);
            default: lim = '1;
        endcase
        set_coeffs({8'($urandom), a}, g[GAIN_BITS-1:0], {12'($urandom), lim});
    endtask

    // Mostly complete plane scans; a few words carry a random plane mark.
    task automatic run_planes(input int n_items);
        int            left;
        int            plane_len;
        logic [SB-1:0] smp;
        logic          first;
        left = n_items;
        while (left > 0)
        begin
            plane_len = ($urandom_range(9) == 0) ? $urandom_range(65, 256)
                                                 : $urandom_range(1, 64);
            for (int ch = 0; ch < plane_len && left > 0; ch++)
            begin
                case ($urandom_range(9))
                    0:       smp = '0;
                    1:       smp = '1;
                    2:       smp = SB'($urandom_range(0, 63));
                    default: smp = SB'($urandom);
                endcase
                first = (ch == 0);
                if ($urandom_range(19) == 0)
                    first = 1'($urandom);
                send_channel(smp, first);
                left--;
            end
        end
    endtask

    task automatic test_reset_defaults;
        send_channel(SB'(0), 1'b1);
        send_channel('1, 1'b0);
        send_channel(SB'(1234), 1'b0);
        drain();
    endtask

    task automatic test_directed_cases;
        // Gain 1.5: exact halves round up.
        set_coeffs(24'd0, 24'd98304, 24'hFFF);
        send_channel(SB'(1), 1'b1);
        send_channel(SB'(3), 1'b0);
        send_channel(SB'(2), 1'b0);
        send_channel('1, 1'b0);
        drain();
        // Largest alpha and gain; the previous value carries over the write.
        set_coeffs(24'h00FFFF, 24'hFFFFFF, 24'hFFF);
        send_channel('1, 1'b0);
        send_channel(SB'(0), 1'b0);
        send_channel('1, 1'b1);
        send_channel('1, 1'b0);
        drain();
        // A gain of zero.
        set_coeffs(24'd13107, 24'd0, 24'hFFF);
        send_channel('1, 1'b1);
        send_channel(SB'(100), 1'b0);
        drain();
        // A gain below one.
        set_coeffs(24'd13107, 24'd40000, 24'hFFF);
        send_channel('1, 1'b1);
        send_channel(SB'(2000), 1'b0);
        send_channel(SB'(1), 1'b0);
        drain();
        // Zero saturation limit, with high register bits set.
        set_coeffs(24'hFF8000, 24'd131072, 24'hABC000);
        send_channel('1, 1'b1);
        send_channel(SB'(17), 1'b0);
        drain();
        // A write to the spare index, then a reduced limit with high bits set.
        cfg_we <= 1'b1;
        cfg_index <= REG_SPARE;
        cfg_data <= '1;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        set_coeffs(24'd6553, 24'd72817, 24'h1237FF);
        send_channel('1, 1'b1);
        send_channel(SB'(2047), 1'b0);
        send_channel(SB'(0), 1'b0);
        send_channel(SB'(4000), 1'b0);
        drain();
    endtask

    task automatic test_idle_phase(input int send_pct, input int stall);
        send_idle_pct = send_pct;
        stall_pct = stall;
        for (int seg = 0; seg < 3; seg++)
        begin
            pick_coeffs();
            run_planes(ITEMS_PER_PHASE / 3);
            drain();
        end
    endtask

    task automatic test_backpressure;
        send_idle_pct = 0;
        stall_pct = 0;
        set_coeffs(24'd3277, 24'd68985, 24'hFFF);
        hold_left = HOLD_CYCLES;
        run_planes(40);
        drain();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_directed_cases();
        test_idle_phase(0, 0);
        test_idle_phase(76, 0);
        test_idle_phase(0, 76);
        test_idle_phase(28, 28);
        test_backpressure();
        repeat (10) @(posedge clk);
        if (bad_words == 0 && pending_corrected.size() == 0)
            $display("feedthrough_crosstalk_correction: match");
        else
            $display("feedthrough_crosstalk_correction: mismatch");
        $finish;
    end

endmodule

[filelist.f]
+incdir+design
design/ftcc_pkg.sv
design/ftcc_in_if.sv
design/ftcc_out_if.sv
design/ftcc_mul.sv
design/feedthrough_crosstalk_correction.sv
bench/testbench.sv
